FILE: src/lfkpp_pkg.sv
// Shared constants and types for the length-framed key packet parser.
// No dependencies; every other file in src but lfkpp_ram imports this package.
package lfkpp_pkg;

    localparam int MAX_PACKET_BYTES = 64;
    localparam int ADDR_W           = $clog2(MAX_PACKET_BYTES);
    localparam int POS_W            = 9;
    localparam int RESULT_LIMIT     = 60;
    localparam int KEY_CFG_W        = 6;
    localparam int IDX_W            = 6;
    localparam int HEAD_BYTES       = 4;

    localparam logic [KEY_CFG_W-1:0] KEY_COUNT_RESET = KEY_CFG_W'(16);

    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] TYPE_IDENTITY = 8'hA2;
    localparam logic [7:0] TYPE_ROUTING  = 8'hA4;
    localparam logic [7:0] TYPE_KEYS     = 8'hA6;
    localparam logic [7:0] TYPE_COMBINED = 8'hA8;

    localparam logic [1:0] KIND_IDENTITY = 2'd0;
    localparam logic [1:0] KIND_ROUTING  = 2'd1;
    localparam logic [1:0] KIND_KEYS     = 2'd2;
    localparam logic [1:0] KIND_COMBINED = 2'd3;

    // Completed packet header, handed from the framer to the drain unit
    typedef struct packed {
        logic                            done;
        logic [7:0]                      ptype;
        logic [POS_W-1:0]                len;
        logic [HEAD_BYTES-1:0][7:0]      head;   // packet bytes 4..7, zero if absent
    } t_pkt;

endpackage

FILE: src/lfkpp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lfkpp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/lfkpp_framer.sv
// Byte framer: sync search, position and length tracking, header capture and
// packet store writes. Depends on lfkpp_pkg.
module lfkpp_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_rx_byte,
    output lfkpp_pkg::t_pkt               o_pkt,
    output logic                          o_wr_en,
    output logic [lfkpp_pkg::ADDR_W-1:0]  o_wr_addr,
    output logic [7:0]                    o_wr_data
);
    import lfkpp_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_exp, n_exp;
    logic             r_done, n_done;
    logic [POS_W-1:0] r_len;
    logic [7:0]       r_type;
    logic [7:0]       r_head [HEAD_BYTES];

    logic             sync_bad;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] exp_eff;
    logic             complete;

    always_comb begin
        sync_bad = (r_pos <= POS_W'(1)) && (i_rx_byte != SYNC_BYTE);
        pos_next = r_pos + POS_W'(1);
        exp_eff  = (r_pos == POS_W'(3)) ? POS_W'(4) + POS_W'(i_rx_byte) : r_exp;
        complete = (pos_next >= POS_W'(4)) && (pos_next == exp_eff);

        n_pos  = r_pos;
        n_exp  = r_exp;
        n_done = 1'b0;
        if (i_accept) begin
            if (sync_bad) begin
                n_pos = '0;
            end else if (complete) begin
                n_pos  = '0;
                n_exp  = '0;
                n_done = 1'b1;
            end else begin
                n_pos = pos_next;
                n_exp = exp_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_exp  <= '0;
            r_done <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_exp  <= n_exp;
            r_done <= n_done;
        end
    end

    // Header capture; head bytes clear at the first sync byte of each packet
    always_ff @(posedge i_clk) begin
        if (i_accept && !sync_bad) begin
            if (r_pos == '0) begin
                for (int j = 0; j < HEAD_BYTES; j++) begin
                    r_head[j] <= '0;
                end
            end
            if (r_pos == POS_W'(2)) begin
                r_type <= i_rx_byte;
            end
            if (r_pos[POS_W-1:2] == (POS_W-2)'(1)) begin
                r_head[r_pos[1:0]] <= i_rx_byte;
            end
            if (complete) begin
                r_len <= pos_next;
            end
        end
    end

    always_comb begin
        o_pkt.done  = r_done;
        o_pkt.ptype = r_type;
        o_pkt.len   = r_len;
        for (int j = 0; j < HEAD_BYTES; j++) begin
            o_pkt.head[j] = r_head[j];
        end
    end

    assign o_wr_en   = i_accept && !sync_bad && (r_pos < POS_W'(MAX_PACKET_BYTES));
    assign o_wr_addr = r_pos[ADDR_W-1:0];
    assign o_wr_data = i_rx_byte;

endmodule

FILE: src/lfkpp_drain.sv
// Result sequencer: decodes a completed packet, reads routing bytes back from
// the packet store and drives the result register. Depends on lfkpp_pkg.
module lfkpp_drain (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lfkpp_pkg::t_pkt                  i_pkt,
    input  logic [lfkpp_pkg::KEY_CFG_W-1:0]  i_key_count,
    output logic                             o_busy,
    output logic                             o_rd_en,
    output logic [lfkpp_pkg::ADDR_W-1:0]     o_rd_addr,
    input  logic [7:0]                       i_rd_data,
    output logic                             o_res_valid,
    input  logic                             i_res_stall,
    output logic [1:0]                       o_kind,
    output logic [31:0]                      o_key_bits,
    output logic [7:0]                       o_cells_reported,
    output logic [7:0]                       o_keys_reported,
    output logic [7:0]                       o_routing_reported,
    output logic [lfkpp_pkg::IDX_W-1:0]      o_routing_index,
    output logic [7:0]                       o_routing_bits,
    output logic                             o_overflow,
    output logic                             o_last
);
    import lfkpp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ONE  = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;

    logic [1:0]       r_kind;
    logic [31:0]      r_key_bits;
    logic [7:0]       r_cells, r_nkeys, r_nrout;
    logic [IDX_W-1:0] r_ridx;
    logic [7:0]       r_rbits;
    logic             r_ovf, r_last;

    logic [3:0]       key_bytes;
    logic [3:0]       start;
    logic [POS_W-1:0] stored;
    logic [POS_W-1:0] avail;
    logic [IDX_W-1:0] n_routes;
    logic             ovf;
    logic [31:0]      keys_all, keys_comb;
    logic [1:0]       route_kind;
    logic [31:0]      route_keys;
    logic             is_routing;
    logic             out_free;
    logic             load_one, load_route;
    logic             route_last;
    logic [POS_W-1:0] rd_pos;

    always_comb begin
        key_bytes = 4'((7'(i_key_count) + 7'd7) >> 3);
        is_routing = (i_pkt.ptype == TYPE_COMBINED) || (i_pkt.ptype == TYPE_ROUTING);
        start  = (i_pkt.ptype == TYPE_COMBINED) ? 4'd4 + key_bytes : 4'd4;
        ovf    = i_pkt.len > POS_W'(MAX_PACKET_BYTES);
        stored = ovf ? POS_W'(MAX_PACKET_BYTES) : i_pkt.len;
        avail  = (stored > POS_W'(start)) ? stored - POS_W'(start) : '0;
        n_routes = (avail > POS_W'(RESULT_LIMIT)) ? IDX_W'(RESULT_LIMIT)
                                                  : avail[IDX_W-1:0];
        keys_all = i_pkt.head;
        for (int j = 0; j < HEAD_BYTES; j++) begin
            keys_comb[j*8 +: 8] = (4'(j) < key_bytes) ? i_pkt.head[j] : 8'h00;
        end
        route_kind = (i_pkt.ptype == TYPE_COMBINED) ? KIND_COMBINED : KIND_ROUTING;
        route_keys = (i_pkt.ptype == TYPE_COMBINED) ? keys_comb : '0;
        rd_pos     = POS_W'(start) + POS_W'(r_idx);
        route_last = (r_idx == n_routes - IDX_W'(1));
    end

    assign out_free = !r_out_valid || !i_res_stall;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_res_stall;
        load_one    = 1'b0;
        load_route  = 1'b0;
        o_rd_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_pkt.done) begin
                    if ((i_pkt.ptype == TYPE_IDENTITY) || (i_pkt.ptype == TYPE_KEYS)) begin
                        n_state = S_ONE;
                    end else if (is_routing) begin
                        n_state = (n_routes == '0) ? S_ONE : S_RD;
                    end
                end
            end
            S_ONE: begin
                if (out_free) begin
                    load_one    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RD: begin
                o_rd_en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // read data holds until the result register frees up
                if (out_free) begin
                    load_route  = 1'b1;
                    n_out_valid = 1'b1;
                    if (route_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_one) begin
            r_ovf   <= ovf;
            r_last  <= 1'b1;
            r_ridx  <= '0;
            r_rbits <= '0;
            r_cells <= '0;
            r_nkeys <= '0;
            r_nrout <= '0;
            case (i_pkt.ptype)
                TYPE_IDENTITY: begin
                    r_kind     <= KIND_IDENTITY;
                    r_key_bits <= '0;
                    r_nkeys    <= i_pkt.head[0];
                    r_cells    <= i_pkt.head[1];
                    r_nrout    <= i_pkt.head[2];
                end
                TYPE_KEYS: begin
                    r_kind     <= KIND_KEYS;
                    r_key_bits <= keys_all;
                end
                default: begin
                    r_kind     <= route_kind;
                    r_key_bits <= route_keys;
                end
            endcase
        end else if (load_route) begin
            r_kind     <= route_kind;
            r_key_bits <= route_keys;
            r_cells    <= '0;
            r_nkeys    <= '0;
            r_nrout    <= '0;
            r_ridx     <= r_idx;
            r_rbits    <= i_rd_data;
            r_ovf      <= ovf;
            r_last     <= route_last;
        end
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_rd_addr          = rd_pos[ADDR_W-1:0];
    assign o_res_valid        = r_out_valid;
    assign o_kind             = r_kind;
    assign o_key_bits         = r_key_bits;
    assign o_cells_reported   = r_cells;
    assign o_keys_reported    = r_nkeys;
    assign o_routing_reported = r_nrout;
    assign o_routing_index    = r_ridx;
    assign o_routing_bits     = r_rbits;
    assign o_overflow         = r_ovf;
    assign o_last             = r_last;

endmodule

FILE: src/length_framed_key_packet_parser.sv
// Channel   | Direction | Handshake             | Payload
// rx        | in        | i_rx_valid/o_rx_stall | i_rx_byte
// result    | out       | o_res_valid/i_res_stall | kind, key bits, counts, routing, flags
// config    | in        | i_cfg_we              | i_cfg_wdata (key count)
//
// A byte that does not end a packet is taken without a stall. The byte that ends
// a packet raises the registered done flag for decode; the result sequencer then
// gives one result for identity, key and empty routing packets, and a read state
// and an output state per stored routing byte. Input stalls while the sequencer runs.
// Reset is synchronous, active low; the packet store is not cleared.
// Top level; depends on lfkpp_pkg, lfkpp_ram, lfkpp_framer and lfkpp_drain.
module length_framed_key_packet_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rx_valid,
    output logic                             o_rx_stall,
    input  logic [7:0]                       i_rx_byte,
    input  logic                             i_cfg_we,
    input  logic [lfkpp_pkg::KEY_CFG_W-1:0]  i_cfg_wdata,
    output logic                             o_res_valid,
    input  logic                             i_res_stall,
    output logic [1:0]                       o_kind,
    output logic [31:0]                      o_key_bits,
    output logic [7:0]                       o_cells_reported,
    output logic [7:0]                       o_keys_reported,
    output logic [7:0]                       o_routing_reported,
    output logic [lfkpp_pkg::IDX_W-1:0]      o_routing_index,
    output logic [7:0]                       o_routing_bits,
    output logic                             o_overflow,
    output logic                             o_last
);
    import lfkpp_pkg::*;

    logic [KEY_CFG_W-1:0] r_key_count;
    logic                 accept;
    logic                 drain_busy;
    t_pkt                 pkt;
    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [7:0]           wr_data, rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= KEY_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_key_count <= i_cfg_wdata;
        end
    end

    // hold input while a finished packet is decoded or drained
    assign o_rx_stall = pkt.done || drain_busy;
    assign accept     = i_rx_valid && !o_rx_stall;

    lfkpp_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_pkt     (pkt),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    lfkpp_ram #(
        .DEPTH (MAX_PACKET_BYTES),
        .WIDTH (8)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lfkpp_drain u_drain (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_pkt              (pkt),
        .i_key_count        (r_key_count),
        .o_busy             (drain_busy),
        .o_rd_en            (rd_en),
        .o_rd_addr          (rd_addr),
        .i_rd_data          (rd_data),
        .o_res_valid        (o_res_valid),
        .i_res_stall        (i_res_stall),
        .o_kind             (o_kind),
        .o_key_bits         (o_key_bits),
        .o_cells_reported   (o_cells_reported),
        .o_keys_reported    (o_keys_reported),
        .o_routing_reported (o_routing_reported),
        .o_routing_index    (o_routing_index),
        .o_routing_bits     (o_routing_bits),
        .o_overflow         (o_overflow),
        .o_last             (o_last)
    );

endmodule
